/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spc assertion failed");

// next-cycle implication
`define SPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spc assertion failed");

`endif

/* rtl/spc_pkg.sv */
package spc_pkg;

  localparam int COORD_W = 32;
  localparam int SIZE_W  = COORD_W - 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = 2 * COORD_W + 2;
  localparam int ROOT_W  = COORD_W + 1;
  localparam int QUO_W   = 15;
  localparam int NORM_W  = 16;
  localparam int DEPTH_W = 32;
  localparam int REM_W   = ROOT_W + 1;
  localparam int DIV_STAGES = QUO_W;

  localparam int IN_DATA_W  = 320;
  localparam int OUT_DATA_W = 64;

  localparam logic signed [NORM_W-1:0] ONE_Q14 = 16'sd16384;

  typedef enum logic [1:0] {
    OP_CC = 2'd0,
    OP_CR = 2'd1,
    OP_RC = 2'd2,
    OP_RR = 2'd3
  } op_t;

  // one pair in flight through the back end
  typedef struct packed {
    logic                      circle;
    logic                      hit;
    logic                      neg_x;
    logic                      neg_y;
    logic                      dist_zero;
    logic [COORD_W-1:0]        mag_x;
    logic [COORD_W-1:0]        mag_y;
    logic [COORD_W-1:0]        radius;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic [DEPTH_W-1:0]        depth;
  } ctx_t;

endpackage

/* rtl/spc_front.sv */
module spc_front import spc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  op_t                       op,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic [SIZE_W-1:0]         a_radius,
  input  logic [SIZE_W-1:0]         a_width,
  input  logic [SIZE_W-1:0]         a_height,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic [SIZE_W-1:0]         b_radius,
  input  logic [SIZE_W-1:0]         b_width,
  input  logic [SIZE_W-1:0]         b_height,
  input  logic                      q_full,
  output logic                      out_valid,
  output ctx_t                      out_ctx
);

  logic signed [DIFF_W-1:0] dx, dy, px, py, hx, hy, ex, ey;
  logic [SIZE_W-1:0]        w_sel, h_sel;
  logic [DIFF_W-1:0]        mex, mey, adx, ady;
  logic [COORD_W-1:0]       rad;
  logic                     neg;
  logic [COORD_W-1:0]       sum_w, sum_h;
  logic signed [DIFF_W:0]   xo, yo;
  ctx_t                     ctx_next;

  assign dx = DIFF_W'(a_x) - DIFF_W'(b_x);
  assign dy = DIFF_W'(a_y) - DIFF_W'(b_y);

  // circle side: offset, clamp box and radius per shape pair
  always_comb begin
    neg   = 1'b0;
    px    = dx;
    py    = dy;
    w_sel = '0;
    h_sel = '0;
    rad   = '0;
    unique case (op)
      OP_CC: begin
        rad = COORD_W'(a_radius) + COORD_W'(b_radius);
      end
      OP_CR: begin
        w_sel = b_width;
        h_sel = b_height;
        rad   = COORD_W'(a_radius);
      end
      OP_RC: begin
        neg   = 1'b1;
        px    = -dx;
        py    = -dy;
        w_sel = a_width;
        h_sel = a_height;
        rad   = COORD_W'(b_radius);
      end
      OP_RR: begin
        rad = '0;
      end
      default: rad = '0;
    endcase
  end

  assign hx = $signed({{(DIFF_W-SIZE_W+1){1'b0}}, w_sel[SIZE_W-1:1]});
  assign hy = $signed({{(DIFF_W-SIZE_W+1){1'b0}}, h_sel[SIZE_W-1:1]});

  // offset from the nearest box point to the circle centre
  always_comb begin
    if (px > hx) begin
      ex = px - hx;
    end else if (px < -hx) begin
      ex = px + hx;
    end else begin
      ex = '0;
    end
    if (py > hy) begin
      ey = py - hy;
    end else if (py < -hy) begin
      ey = py + hy;
    end else begin
      ey = '0;
    end
  end

  assign mex = ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
  assign mey = ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
  assign adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  // box against box overlaps
  assign sum_w = COORD_W'(a_width) + COORD_W'(b_width);
  assign sum_h = COORD_W'(a_height) + COORD_W'(b_height);
  assign xo = $signed({3'b000, sum_w[COORD_W-1:1]}) - $signed({1'b0, adx});
  assign yo = $signed({3'b000, sum_h[COORD_W-1:1]}) - $signed({1'b0, ady});

  always_comb begin
    ctx_next           = '0;
    ctx_next.circle    = (op != OP_RR);
    ctx_next.neg_x     = ex[DIFF_W-1] ^ neg;
    ctx_next.neg_y     = ey[DIFF_W-1] ^ neg;
    ctx_next.mag_x     = mex[COORD_W-1:0];
    ctx_next.mag_y     = mey[COORD_W-1:0];
    ctx_next.radius    = rad;
    if (op != OP_RR) begin
      ctx_next.hit = (mex <= DIFF_W'(rad)) && (mey <= DIFF_W'(rad));
    end else if (xo > 0 && yo > 0) begin
      ctx_next.hit = 1'b1;
      if (xo < yo) begin
        ctx_next.nx    = (!dx[DIFF_W-1] && dx != 0) ? ONE_Q14 : -ONE_Q14;
        ctx_next.depth = xo[DEPTH_W-1:0];
      end else begin
        ctx_next.ny    = (!dy[DIFF_W-1] && dy != 0) ? ONE_Q14 : -ONE_Q14;
        ctx_next.depth = yo[DEPTH_W-1:0];
      end
    end
  end

  assign in_ready = !out_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctx <= ctx_next;
    end
  end

endmodule

/* rtl/spc_queue.sv */
`include "assert_macros.svh"

module spc_queue import spc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  ctx_t push_ctx,
  input  logic pop,
  output logic full,
  output logic valid,
  output ctx_t head
);

  ctx_t       mem [2];
  logic [1:0] cnt;
  logic       wptr, rptr;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_ctx;
    end
  end

  `SPC_ASSERT_NEXT(q_fill_step, push && !pop, cnt == $past(cnt) + 2'd1)

endmodule

/* rtl/spc_sqrt.sv */
module spc_sqrt import spc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  ctx_t              in_ctx,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output ctx_t              out_ctx
);

  logic              v    [ROOT_W+1];
  logic [SUM_W:0]    rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  ctx_t              ctx  [ROOT_W+1];

  assign v[0]    = in_valid;
  assign rem[0]  = {1'b0, in_sum};
  assign root[0] = '0;
  assign ctx[0]  = in_ctx;

  // one root bit per stage, msb first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
    localparam int K = ROOT_W - 1 - i;
    logic [SUM_W:0] trial;
    logic           fits;

    assign trial = ({{(SUM_W+1-ROOT_W){1'b0}}, root[i]} << (K + 1))
                 | ((SUM_W+1)'(1) << (2 * K));
    assign fits  = (rem[i] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= fits ? rem[i] - trial : rem[i];
        root[i+1] <= fits ? root[i] | (ROOT_W'(1) << K) : root[i];
        ctx[i+1]  <= ctx[i];
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_ctx   = ctx[ROOT_W];

endmodule

/* rtl/spc_div.sv */
module spc_div import spc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_dist,
  input  ctx_t              in_ctx,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_qx,
  output logic [QUO_W-1:0]  out_qy,
  output ctx_t              out_ctx
);

  logic              v    [DIV_STAGES+1];
  logic [ROOT_W-1:0] dvsr [DIV_STAGES+1];
  logic [REM_W-1:0]  rx   [DIV_STAGES+1];
  logic [REM_W-1:0]  ry   [DIV_STAGES+1];
  logic [QUO_W-1:0]  qx   [DIV_STAGES+1];
  logic [QUO_W-1:0]  qy   [DIV_STAGES+1];
  ctx_t              ctx  [DIV_STAGES+1];
  ctx_t              prep;

  // depth and the zero distance flag are settled before the divide
  always_comb begin
    prep           = in_ctx;
    prep.dist_zero = (in_dist == '0);
    if (in_ctx.circle) begin
      prep.depth = DEPTH_W'(in_ctx.radius - in_dist[COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvsr[0] <= in_dist;
      rx[0]   <= REM_W'(in_ctx.mag_x);
      ry[0]   <= REM_W'(in_ctx.mag_y);
      qx[0]   <= '0;
      qy[0]   <= '0;
      ctx[0]  <= prep;
    end
  end

  // restoring divide, one quotient bit per stage for both axes
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    logic [REM_W-1:0] tx, ty;
    logic             bx, by;

    assign tx = (j == 0) ? rx[j] : (rx[j] << 1);
    assign ty = (j == 0) ? ry[j] : (ry[j] << 1);
    assign bx = (tx >= REM_W'(dvsr[j]));
    assign by = (ty >= REM_W'(dvsr[j]));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[j+1]   <= bx ? tx - REM_W'(dvsr[j]) : tx;
        ry[j+1]   <= by ? ty - REM_W'(dvsr[j]) : ty;
        qx[j+1]   <= {qx[j][QUO_W-2:0], bx};
        qy[j+1]   <= {qy[j][QUO_W-2:0], by};
        dvsr[j+1] <= dvsr[j];
        ctx[j+1]  <= ctx[j];
      end
    end
  end

  assign out_valid = v[DIV_STAGES];
  assign out_qx    = qx[DIV_STAGES];
  assign out_qy    = qy[DIV_STAGES];
  assign out_ctx   = ctx[DIV_STAGES];

endmodule

/* rtl/spc_back.sv */
`include "assert_macros.svh"

module spc_back import spc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  ctx_t                     in_ctx,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic signed [NORM_W-1:0] out_nx,
  output logic signed [NORM_W-1:0] out_ny,
  output logic [DEPTH_W-1:0]       out_depth
);

  logic              en;
  logic              v0, v1;
  ctx_t              c0, c1, c1_next;
  logic [SQ_W-1:0]   sqx, sqy, sqr;
  logic [SUM_W-1:0]  s1, s_next;
  logic              sq_valid;
  logic [ROOT_W-1:0] root_len;
  ctx_t              sq_ctx;
  logic              dv_valid;
  logic [QUO_W-1:0]  qx, qy;
  ctx_t              dv_ctx;
  logic signed [NORM_W-1:0] nx_c, ny_c, nx_next, ny_next;

  assign en  = !out_valid || out_ready;
  assign pop = en && in_valid;

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
  end

  assign s_next = SUM_W'(sqx) + SUM_W'(sqy);

  always_comb begin
    c1_next = c0;
    if (c0.circle) begin
      c1_next.hit = c0.hit && (s_next <= SUM_W'(sqr));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0  <= in_ctx;
      sqx <= in_ctx.mag_x * in_ctx.mag_x;
      sqy <= in_ctx.mag_y * in_ctx.mag_y;
      sqr <= in_ctx.radius * in_ctx.radius;
      c1  <= c1_next;
      s1  <= s_next;
    end
  end

  spc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_sum    (s1),
    .in_ctx    (c1),
    .out_valid (sq_valid),
    .out_root  (root_len),
    .out_ctx   (sq_ctx)
  );

  spc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_dist   (root_len),
    .in_ctx    (sq_ctx),
    .out_valid (dv_valid),
    .out_qx    (qx),
    .out_qy    (qy),
    .out_ctx   (dv_ctx)
  );

  assign nx_c = dv_ctx.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ny_c = dv_ctx.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_comb begin
    if (!dv_ctx.hit) begin
      nx_next = '0;
      ny_next = '0;
    end else if (dv_ctx.circle) begin
      nx_next = dv_ctx.dist_zero ? '0 : nx_c;
      ny_next = dv_ctx.dist_zero ? '0 : ny_c;
    end else begin
      nx_next = dv_ctx.nx;
      ny_next = dv_ctx.ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit   <= dv_ctx.hit;
      out_nx    <= nx_next;
      out_ny    <= ny_next;
      out_depth <= dv_ctx.hit ? dv_ctx.depth : '0;
    end
  end

  `SPC_ASSERT_IMPL(miss_all_zero, out_valid && !out_hit, out_nx == 0 && out_ny == 0 && out_depth == 0)
  `SPC_ASSERT_IMPL(normal_in_range, out_valid && out_hit, out_nx <= ONE_Q14 && out_nx >= -ONE_Q14 && out_ny <= ONE_Q14 && out_ny >= -ONE_Q14)

endmodule

/* rtl/shape_pair_collision_test_core.sv */
// narrow-phase collision test for one pair of 2-d colliders (circle or
// axis-aligned box each). a pair enters per beat on the s_ side and one
// contact beat leaves on the m_ side: hit, normal toward the first collider
// (q2.14) and penetration depth (q16.16); a miss gives all zeros and
// coincident circle points give a zero normal. the core takes a new pair every
// clock unless back-pressure on m_tready has filled its queue; a pair passes
// the front register, the queue, the registers for squares and the sum, the
// bit-per-stage square root, the per-bit normal divide and one output register.
// the front end and its two-entry queue keep s_tready off any combinational
// path from m_tready.
module shape_pair_collision_test_core import spc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // a_x, a_y, a_radius, a_width, a_height, b_x, b_y, b_radius, b_width,
  // b_height, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // normal_x, normal_y, depth
  output logic [OUT_DATA_W-1:0] m_tdata,
  // hit
  output logic [0:0]            m_tuser
);

  logic                     fr_valid, q_full, q_valid, q_pop;
  ctx_t                     fr_ctx, q_head;
  logic                     hit;
  logic signed [NORM_W-1:0] nx, ny;
  logic [DEPTH_W-1:0]       depth;

  // front: offsets, clamps and the whole box-box answer
  spc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (op_t'(s_tuser)),
    .a_x       ($signed(s_tdata[31:0])),
    .a_y       ($signed(s_tdata[63:32])),
    .a_radius  (s_tdata[94:64]),
    .a_width   (s_tdata[125:95]),
    .a_height  (s_tdata[156:126]),
    .b_x       ($signed(s_tdata[188:157])),
    .b_y       ($signed(s_tdata[220:189])),
    .b_radius  (s_tdata[251:221]),
    .b_width   (s_tdata[282:252]),
    .b_height  (s_tdata[313:283]),
    .q_full    (q_full),
    .out_valid (fr_valid),
    .out_ctx   (fr_ctx)
  );

  // two-entry queue between classification and the arithmetic pipe
  spc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fr_valid && !q_full),
    .push_ctx (fr_ctx),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  // back: squares, root, normal divide, output register
  spc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ctx    (q_head),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hit   (hit),
    .out_nx    (nx),
    .out_ny    (ny),
    .out_depth (depth)
  );

  assign m_tdata = {depth, ny, nx};
  assign m_tuser = hit;

endmodule
